// ===== hw/rtl/mtlt_pkg.sv =====
package mtlt_pkg;

    localparam int LAYER_COUNT    = 32;
    localparam int EXCLUDED_SLOTS = 4;
    localparam int EXCL_LIM       = (EXCLUDED_SLOTS < 4) ? EXCLUDED_SLOTS : 4;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    typedef enum logic [2:0] {
        KIND_MOTION = 3'd0,
        KIND_KEY    = 3'd1,
        KIND_PRESS  = 3'd2,
        KIND_TICK   = 3'd3,
        KIND_NOTICE = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        REG_THRESHOLD = 3'd0,
        REG_WINDOW    = 3'd1,
        REG_IDLE      = 3'd2,
        REG_HOLD      = 3'd3,
        REG_LAYER     = 3'd4,
        REG_EXCL_LIST = 3'd5,
        REG_EXCL_CNT  = 3'd6
    } t_reg_idx;

    localparam logic [15:0] RST_THRESHOLD = 16'd100;
    localparam logic [15:0] RST_WINDOW    = 16'd50;
    localparam logic [14:0] RST_IDLE      = 15'd0;
    localparam logic [15:0] RST_HOLD      = 16'd0;
    localparam logic [4:0]  RST_LAYER     = 5'd1;
    localparam logic [31:0] RST_EXCL_LIST = 32'd0;
    localparam logic [2:0]  RST_EXCL_CNT  = 3'd0;

endpackage

// ===== hw/rtl/motion_threshold_layer_trigger.sv =====
// Path: a word accepted into the input register is presented on the output from the result register.
// Throughput: one word per cycle; input register feeds one pass of logic into the
// result register, and both registers hold while the output side stalls.
// Reset (synchronous, active low): all trigger state and both valid flags clear;
// configuration registers return to their defaults (threshold 100, window 50,
// idle 0, hold 0, layer 1, no excluded positions).
module motion_threshold_layer_trigger
    import mtlt_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,

    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [2:0]               i_kind,
    input  logic signed [15:0]       i_motion_delta,
    input  logic [7:0]               i_position,
    input  logic                     i_layer_still_on,

    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic                     o_layer_active,
    output logic                     o_turn_on,
    output logic                     o_turn_off,
    output logic [4:0]               o_layer_index,

    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ADDR_W-1:0]        paddr,
    input  logic [DATA_W-1:0]        pwdata,
    output logic [DATA_W-1:0]        prdata,
    output logic                     pready
);

    // configuration
    logic [15:0] r_threshold;
    logic [15:0] r_window;
    logic [14:0] r_idle;
    logic [15:0] r_hold;
    logic [4:0]  r_layer;
    logic [31:0] r_excl_list;
    logic [2:0]  r_excl_cnt;

    // trigger state
    logic        r_active,     n_active;
    logic        r_accum,      n_accum;
    logic [15:0] r_sum,        n_sum;
    logic [15:0] r_elapsed,    n_elapsed;
    logic [14:0] r_since_key,  n_since_key;
    logic [15:0] r_hold_rem,   n_hold_rem;
    logic        r_hold_run,   n_hold_run;
    logic        n_on,         n_off;

    // input register
    logic              r_in_valid;
    logic [2:0]        r_kind;
    logic signed [15:0] r_motion_delta;
    logic [7:0]        r_position;
    logic              r_still_on;

    // result register
    logic        r_out_valid;
    logic        r_layer_active;
    logic        r_turn_on;
    logic        r_turn_off;
    logic [4:0]  r_layer_index;

    logic        w_advance;
    logic        w_in_accept;
    logic        w_step;
    logic        w_cfg_wr;
    t_reg_idx    w_reg_idx;

    logic [15:0] w_raw;
    logic [15:0] w_mag;
    logic [15:0] w_sum_eff;
    logic        w_restart;
    logic        w_hit;
    logic        w_excluded;
    logic [2:0]  w_excl_n;
    logic [15:0] w_rem_dec;

    assign w_advance   = !(r_out_valid && i_out_stall);
    assign o_in_stall  = r_in_valid && !w_advance;
    assign w_in_accept = i_in_valid && !o_in_stall;
    assign w_step      = r_in_valid && w_advance;

    assign o_out_valid    = r_out_valid;
    assign o_layer_active = r_layer_active;
    assign o_turn_on      = r_turn_on;
    assign o_turn_off     = r_turn_off;
    assign o_layer_index  = r_layer_index;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_reg_idx = t_reg_idx'(paddr[ADDR_W-1:2]);

    always_comb begin
        case (w_reg_idx)
            REG_THRESHOLD: prdata = DATA_W'(r_threshold);
            REG_WINDOW:    prdata = DATA_W'(r_window);
            REG_IDLE:      prdata = DATA_W'(r_idle);
            REG_HOLD:      prdata = DATA_W'(r_hold);
            REG_LAYER:     prdata = DATA_W'(r_layer);
            REG_EXCL_LIST: prdata = DATA_W'(r_excl_list);
            REG_EXCL_CNT:  prdata = DATA_W'(r_excl_cnt);
            default:       prdata = '0;
        endcase
    end

    // magnitude; the most negative delta maps to 32768, which still fits 16 bits
    assign w_raw     = unsigned'(r_motion_delta);
    assign w_mag     = w_raw[15] ? (~w_raw + 16'd1) : w_raw;
    assign w_restart = !r_accum || (r_elapsed >= r_window);
    assign w_sum_eff = w_restart ? 16'd0 : r_sum;
    assign w_hit     = (w_sum_eff >= r_threshold) || (w_mag >= (r_threshold - w_sum_eff));
    assign w_excl_n  = (r_excl_cnt > 3'(EXCL_LIM)) ? 3'(EXCL_LIM) : r_excl_cnt;
    assign w_rem_dec = (r_hold_rem != 16'd0) ? (r_hold_rem - 16'd1) : r_hold_rem;

    always_comb begin
        w_excluded = 1'b0;
        for (int i = 0; i < EXCL_LIM; i++) begin
            if ((3'(i) < w_excl_n) && (r_excl_list[8*i +: 8] == r_position)) begin
                w_excluded = 1'b1;
            end
        end
    end

    always_comb begin
        n_active    = r_active;
        n_accum     = r_accum;
        n_sum       = r_sum;
        n_elapsed   = r_elapsed;
        n_since_key = r_since_key;
        n_hold_rem  = r_hold_rem;
        n_hold_run  = r_hold_run;
        n_on        = 1'b0;
        n_off       = 1'b0;
        case (t_kind'(r_kind))
            KIND_MOTION: begin
                if ((w_raw != 16'd0) && (32'(r_layer) < LAYER_COUNT)) begin
                    if (r_active) begin
                        if (r_hold != 16'd0) begin
                            n_hold_rem = r_hold;
                            n_hold_run = 1'b1;
                        end
                    end else if (r_since_key < r_idle) begin
                        n_accum   = 1'b0;
                        n_sum     = '0;
                        n_elapsed = '0;
                    end else if (w_hit) begin
                        n_accum   = 1'b0;
                        n_sum     = '0;
                        n_elapsed = '0;
                        n_active  = 1'b1;
                        n_on      = 1'b1;
                        if (r_hold != 16'd0) begin
                            n_hold_rem = r_hold;
                            n_hold_run = 1'b1;
                        end
                    end else begin
                        // restart the window if it has lapsed, then add
                        n_accum = 1'b1;
                        n_sum   = w_sum_eff + w_mag;
                        if (w_restart) begin
                            n_elapsed = '0;
                        end
                    end
                end
            end
            KIND_KEY: begin
                if (r_idle != 15'd0) begin
                    n_since_key = '0;
                    n_accum     = 1'b0;
                    n_sum       = '0;
                    n_elapsed   = '0;
                end
            end
            KIND_PRESS: begin
                if (r_active && (r_excl_cnt != 3'd0) && !w_excluded) begin
                    n_active   = 1'b0;
                    n_accum    = 1'b0;
                    n_sum      = '0;
                    n_elapsed  = '0;
                    n_hold_run = 1'b0;
                    n_hold_rem = '0;
                    n_off      = 1'b1;
                end
            end
            KIND_TICK: begin
                if (r_since_key != 15'h7FFF) begin
                    n_since_key = r_since_key + 15'd1;
                end
                if (r_accum && (r_elapsed != 16'hFFFF)) begin
                    n_elapsed = r_elapsed + 16'd1;
                end
                if (r_hold_run) begin
                    n_hold_rem = w_rem_dec;
                    if (w_rem_dec == 16'd0) begin
                        n_hold_run = 1'b0;
                        if (r_active) begin
                            n_active  = 1'b0;
                            n_accum   = 1'b0;
                            n_sum     = '0;
                            n_elapsed = '0;
                            n_off     = 1'b1;
                        end
                    end
                end
            end
            KIND_NOTICE: begin
                // switched off from outside: drop silently
                if (r_active && !r_still_on) begin
                    n_active   = 1'b0;
                    n_accum    = 1'b0;
                    n_sum      = '0;
                    n_elapsed  = '0;
                    n_hold_run = 1'b0;
                    n_hold_rem = '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= RST_THRESHOLD;
            r_window    <= RST_WINDOW;
            r_idle      <= RST_IDLE;
            r_hold      <= RST_HOLD;
            r_layer     <= RST_LAYER;
            r_excl_list <= RST_EXCL_LIST;
            r_excl_cnt  <= RST_EXCL_CNT;
            r_active    <= 1'b0;
            r_accum     <= 1'b0;
            r_sum       <= '0;
            r_elapsed   <= '0;
            r_since_key <= '0;
            r_hold_rem  <= '0;
            r_hold_run  <= 1'b0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_cfg_wr) begin
                case (w_reg_idx)
                    REG_THRESHOLD: r_threshold <= pwdata[15:0];
                    REG_WINDOW:    r_window    <= pwdata[15:0];
                    REG_IDLE:      r_idle      <= pwdata[14:0];
                    REG_HOLD:      r_hold      <= pwdata[15:0];
                    REG_LAYER:     r_layer     <= pwdata[4:0];
                    REG_EXCL_LIST: r_excl_list <= pwdata[31:0];
                    REG_EXCL_CNT:  r_excl_cnt  <= pwdata[2:0];
                    default: begin
                    end
                endcase
            end
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (w_advance) begin
                r_out_valid <= r_in_valid;
            end
            if (w_step) begin
                r_active    <= n_active;
                r_accum     <= n_accum;
                r_sum       <= n_sum;
                r_elapsed   <= n_elapsed;
                r_since_key <= n_since_key;
                r_hold_rem  <= n_hold_rem;
                r_hold_run  <= n_hold_run;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_kind         <= i_kind;
            r_motion_delta <= i_motion_delta;
            r_position     <= i_position;
            r_still_on     <= i_layer_still_on;
        end
        if (w_step) begin
            r_layer_active <= n_active;
            r_turn_on      <= n_on;
            r_turn_off     <= n_off;
            r_layer_index  <= r_layer;
        end
    end

`ifndef SYNTHESIS
    a_on_off_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_turn_on && o_turn_off))
        else $error("turn_on and turn_off in one word");

    a_on_means_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_turn_on) |-> o_layer_active)
        else $error("turn_on without layer active");

    a_off_means_inactive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_turn_off) |-> !o_layer_active)
        else $error("turn_off with layer still active");

    a_hold_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hold_run |-> (r_hold_rem != 16'd0))
        else $error("hold timer running at zero");

    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && r_in_valid))
        else $error("input stalled with no blocked result");
`endif

endmodule

// ===== bench/testbench.sv =====
module testbench;
    import mtlt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY     = 2;
    localparam int QUIET_LIMIT = 1000;
    localparam int HOLD_OFF    = 150;
    localparam int PHASE_WORDS = 250;
    localparam logic [2:0] KIND_SPARE_LO = 3'd5;
    localparam logic [2:0] KIND_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] delta;
        logic [7:0]  pos;
        logic        still_on;
    } t_event_word;

    typedef struct packed {
        logic       layer_active;
        logic       turn_on;
        logic       turn_off;
        logic [4:0] layer_index;
    } t_layer_request;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [2:0]         i_kind = KIND_TICK;
    logic signed [15:0] i_motion_delta = '0;
    logic [7:0]         i_position = '0;
    logic               i_layer_still_on = 1'b0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic               o_layer_active;
    logic               o_turn_on;
    logic               o_turn_off;
    logic [4:0]         o_layer_index;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [ADDR_W-1:0]  paddr = '0;
    logic [DATA_W-1:0]  pwdata = '0;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    motion_threshold_layer_trigger dut (.*);

    // register copies
    logic [15:0] cfg_threshold = RST_THRESHOLD;
    logic [15:0] cfg_window    = RST_WINDOW;
    logic [14:0] cfg_idle      = RST_IDLE;
    logic [15:0] cfg_hold      = RST_HOLD;
    logic [4:0]  cfg_layer     = RST_LAYER;
    logic [31:0] cfg_excl_list = RST_EXCL_LIST;
    logic [2:0]  cfg_excl_cnt  = RST_EXCL_CNT;

    // trigger state
    logic        layer_on   = 1'b0;
    logic        summing    = 1'b0;
    logic [15:0] motion_acc = '0;
    logic [15:0] window_age = '0;
    logic [14:0] key_age    = '0;
    logic [15:0] hold_left  = '0;
    logic        hold_armed = 1'b0;

    t_event_word    event_words[$];
    t_layer_request layer_requests_due[$];
    t_event_word    offered;
    t_layer_request due, want;

    int  words_in = 0;
    int  results_seen = 0;
    int  failures = 0;
    int  hold_off_left = 0;
    bit  pressure_done = 1'b0;
    logic steady;

    assign steady = (words_in >= 800) && (words_in < 1100);

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic void clear_sum();
        summing    = 1'b0;
        motion_acc = '0;
        window_age = '0;
    endfunction

    function automatic void drop_layer();
        layer_on = 1'b0;
        clear_sum();
        hold_armed = 1'b0;
        hold_left  = '0;
    endfunction

    function automatic void arm_hold();
        if (cfg_hold != 0) begin
            hold_left  = cfg_hold;
            hold_armed = 1'b1;
        end
    endfunction

    function automatic t_layer_request predict_layer_request(input t_event_word w);
        t_layer_request r;
        logic [15:0]    mag;
        logic           on_now;
        logic           off_now;
        logic           spared;
        int             slots;
        on_now  = 1'b0;
        off_now = 1'b0;
        spared  = 1'b0;
        mag = w.delta[15] ? 16'(-w.delta) : w.delta;
        case (w.kind)
            KIND_MOTION: begin
                if (w.delta != 0 && int'(cfg_layer) < LAYER_COUNT) begin
                    if (layer_on) begin
                        arm_hold();
                    end else if (key_age < cfg_idle) begin
                        clear_sum();
                    end else begin
                        if (!summing || window_age >= cfg_window) begin
                            clear_sum();
                            summing = 1'b1;
                        end
                        if (motion_acc >= cfg_threshold || mag >= cfg_threshold - motion_acc) begin
                            clear_sum();
                            layer_on = 1'b1;
                            on_now   = 1'b1;
                            arm_hold();
                        end else begin
                            motion_acc = motion_acc + mag;
                        end
                    end
                end
            end
            KIND_KEY: begin
                if (cfg_idle != 0) begin
                    key_age = '0;
                    clear_sum();
                end
            end
            KIND_PRESS: begin
                slots = (int'(cfg_excl_cnt) > EXCL_LIM) ? EXCL_LIM : int'(cfg_excl_cnt);
                for (int s = 0; s < slots; s++)
                    if (cfg_excl_list[8*s +: 8] == w.pos)
                        spared = 1'b1;
                if (layer_on && cfg_excl_cnt != 0 && !spared) begin
                    drop_layer();
                    off_now = 1'b1;
                end
            end
            KIND_TICK: begin
                if (key_age != 15'h7fff)
                    key_age = key_age + 1'b1;
                if (summing && window_age != 16'hffff)
                    window_age = window_age + 1'b1;
                if (hold_armed) begin
                    if (hold_left != 0)
                        hold_left = hold_left - 1'b1;
                    if (hold_left == 0) begin
                        hold_armed = 1'b0;
                        if (layer_on) begin
                            drop_layer();
                            off_now = 1'b1;
                        end
                    end
                end
            end
            KIND_NOTICE: begin
                if (layer_on && !w.still_on)
                    drop_layer();
            end
            default: begin
            end
        endcase
        r.layer_active = layer_on;
        r.turn_on      = on_now;
        r.turn_off     = off_now;
        r.layer_index  = cfg_layer;
        return r;
    endfunction

    // sender: offer the next word unless idling; hold it while stalled
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                due = predict_layer_request(offered);
                layer_requests_due.push_back(due);
                words_in++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (event_words.size() != 0 && (steady || $urandom_range(99) >= 19)) begin
                    offered = event_words.pop_front();
                    i_kind           <= offered.kind;
                    i_motion_delta   <= offered.delta;
                    i_position       <= offered.pos;
                    i_layer_still_on <= offered.still_on;
                    i_in_valid       <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: check each word against the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                if (layer_requests_due.size() == 0) begin
                    $error("result word with nothing expected");
                    failures++;
                end else begin
                    want = layer_requests_due.pop_front();
                    if (o_layer_active !== want.layer_active) begin
                        $error("layer_active: expected %0d, got %0d",
                               want.layer_active, o_layer_active);
                        failures++;
                    end
                    if (o_turn_on !== want.turn_on) begin
                        $error("turn_on: expected %0d, got %0d", want.turn_on, o_turn_on);
                        failures++;
                    end
                    if (o_turn_off !== want.turn_off) begin
                        $error("turn_off: expected %0d, got %0d", want.turn_off, o_turn_off);
                        failures++;
                    end
                    if (o_layer_index !== want.layer_index) begin
                        $error("layer_index: expected %0d, got %0d",
                               want.layer_index, o_layer_index);
                        failures++;
                    end
                end
            end
            // hold off once for a long stretch so the block backs up into its input
            if (hold_off_left > 0) begin
                hold_off_left--;
                i_out_stall <= 1'b1;
            end else if (!pressure_done && results_seen >= 300 && event_words.size() > 100) begin
                pressure_done = 1'b1;
                hold_off_left = HOLD_OFF;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= !steady && ($urandom_range(99) < 19);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic reg_write(input t_reg_idx idx, input logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(int'(idx) * 4);
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_THRESHOLD: cfg_threshold = value[15:0];
            REG_WINDOW:    cfg_window    = value[15:0];
            REG_IDLE:      cfg_idle      = value[14:0];
            REG_HOLD:      cfg_hold      = value[15:0];
            REG_LAYER:     cfg_layer     = value[4:0];
            REG_EXCL_LIST: cfg_excl_list = value;
            REG_EXCL_CNT:  cfg_excl_cnt  = value[2:0];
            default: begin
            end
        endcase
    endtask

    task automatic load_settings(input logic [15:0] thr, input logic [15:0] win,
                                 input logic [14:0] idle, input logic [15:0] hold,
                                 input logic [4:0] layer, input logic [31:0] excl,
                                 input logic [2:0] cnt);
        reg_write(REG_THRESHOLD, 32'(thr));
        reg_write(REG_WINDOW, 32'(win));
        reg_write(REG_IDLE, 32'(idle));
        reg_write(REG_HOLD, 32'(hold));
        reg_write(REG_LAYER, 32'(layer));
        reg_write(REG_EXCL_LIST, excl);
        reg_write(REG_EXCL_CNT, 32'(cnt));
    endtask

    task automatic queue_word(input logic [2:0] kind, input logic [15:0] delta,
                              input logic [7:0] pos, input logic still_on);
        t_event_word w;
        w.kind     = kind;
        w.delta    = delta;
        w.pos      = pos;
        w.still_on = still_on;
        event_words.push_back(w);
    endtask

    // wait until every word is through and the block has settled
    task automatic drain();
        do @(negedge i_clk);
        while (event_words.size() != 0 || i_in_valid || layer_requests_due.size() != 0);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    function automatic t_event_word random_word();
        t_event_word w;
        int          pick;
        int          mag;
        pick       = $urandom_range(99);
        w.delta    = 16'($urandom);
        w.pos      = 8'($urandom);
        w.still_on = 1'($urandom);
        if (pick < 45)      w.kind = KIND_MOTION;
        else if (pick < 75) w.kind = KIND_TICK;
        else if (pick < 85) w.kind = KIND_PRESS;
        else if (pick < 90) w.kind = KIND_KEY;
        else if (pick < 96) w.kind = KIND_NOTICE;
        else                w.kind = 3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
        pick = $urandom_range(99);
        // mostly moderate deltas so sums build up over several words
        if (pick < 10) begin
            w.delta = '0;
        end else if (pick < 15) begin
            case ($urandom_range(3))
                0: w.delta = 16'h8000;
                1: w.delta = 16'h7fff;
                2: w.delta = 16'hffff;
                default: w.delta = 16'h0001;
            endcase
        end else if (pick >= 25) begin
            mag = $urandom_range(1, int'(cfg_threshold) * 2 / 3 + 1);
            if (mag > 32767) mag = 32767;
            w.delta = $urandom_range(1) ? 16'(-mag) : 16'(mag);
        end
        if ($urandom_range(1))
            w.pos = cfg_excl_list[8*$urandom_range(3) +: 8];
        return w;
    endfunction

    initial begin : stimulus
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // defaults: threshold 100, no idle, no hold, no exclusions
        queue_word(KIND_MOTION, 16'd0, 8'd0, 1'b0);
        queue_word(KIND_MOTION, 16'd50, 8'd0, 1'b0);
        queue_word(KIND_MOTION, -16'sd49, 8'd0, 1'b0);
        queue_word(KIND_MOTION, 16'd1, 8'd0, 1'b0);
        queue_word(KIND_MOTION, 16'h8000, 8'd0, 1'b0);
        queue_word(KIND_PRESS, 16'd0, 8'd3, 1'b0);
        queue_word(KIND_KEY, 16'd0, 8'd0, 1'b0);
        queue_word(KIND_NOTICE, 16'd0, 8'd0, 1'b1);
        queue_word(KIND_NOTICE, 16'd0, 8'd0, 1'b0);
        queue_word(KIND_SPARE_HI, 16'hffff, 8'hff, 1'b1);
        queue_word(KIND_MOTION, 16'h7fff, 8'd0, 1'b0);
        drain();

        // top threshold, one-tick window, idle and hold, oversized exclusion count
        load_settings(16'hffff, 16'd1, 15'd3, 16'd2, 5'd31, 32'hffa5_0100, 3'd7);
        queue_word(KIND_PRESS, 16'd0, 8'h01, 1'b0);
        queue_word(KIND_PRESS, 16'd0, 8'hff, 1'b0);
        queue_word(KIND_PRESS, 16'd0, 8'h7e, 1'b0);
        queue_word(KIND_KEY, 16'd0, 8'd0, 1'b0);
        queue_word(KIND_MOTION, 16'd10, 8'd0, 1'b0);
        repeat (3) queue_word(KIND_TICK, 16'd0, 8'd0, 1'b0);
        queue_word(KIND_MOTION, 16'h7fff, 8'd0, 1'b0);
        queue_word(KIND_TICK, 16'd0, 8'd0, 1'b0);
        queue_word(KIND_MOTION, 16'h8000, 8'd0, 1'b0);
        queue_word(KIND_MOTION, 16'h8000, 8'd0, 1'b0);
        queue_word(KIND_TICK, 16'd0, 8'd0, 1'b0);
        queue_word(KIND_MOTION, 16'd5, 8'd0, 1'b0);
        repeat (2) queue_word(KIND_TICK, 16'd0, 8'd0, 1'b0);
        drain();

        // lower the threshold beneath a running sum, then retarget while on
        load_settings(16'd1000, 16'd50, 15'd0, 16'd0, 5'd0, 32'h0000_0000, 3'd1);
        queue_word(KIND_MOTION, 16'd900, 8'd0, 1'b0);
        drain();
        reg_write(REG_THRESHOLD, 32'd10);
        queue_word(KIND_MOTION, 16'd1, 8'd0, 1'b0);
        drain();
        reg_write(REG_LAYER, 32'd5);
        queue_word(KIND_PRESS, 16'd0, 8'd0, 1'b0);
        queue_word(KIND_NOTICE, 16'd0, 8'd0, 1'b0);
        drain();

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: load_settings(16'd1, 16'd1, 15'd0, 16'd0, 5'd0, 32'h0, 3'd0);
                1: load_settings(16'hffff, 16'hffff, 15'h7fff, 16'hffff, 5'd31,
                                 32'hffff_ffff, 3'd7);
                default: load_settings(16'($urandom_range(1, 400)),
                                       16'($urandom_range(1, 30)),
                                       15'($urandom_range(1) ? $urandom_range(0, 8) : 0),
                                       16'($urandom_range(0, 25)),
                                       5'($urandom),
                                       32'($urandom),
                                       3'($urandom_range(0, 7)));
            endcase
            repeat (PHASE_WORDS) event_words.push_back(random_word());
            drain();
        end

        repeat (LATENCY + 4) @(posedge i_clk);
        if (failures == 0 && layer_requests_due.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/mtlt_pkg.sv
hw/rtl/motion_threshold_layer_trigger.sv
bench/testbench.sv
